// File: src/fn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fn_pkg
// shared widths, types and sequencer states of the fraction normalizer
// ----------------------------------------------------------------------------
package fn_pkg;

	localparam int WIDTH       = 32;
	localparam int MAG_W       = WIDTH - 1;
	localparam int K_W         = $clog2(MAG_W);
	localparam int CNT_W       = $clog2(MAG_W);
	localparam int IN_TDATA_W  = 2 * WIDTH;
	localparam int OUT_BITS    = WIDTH + MAG_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STRIP,
		ST_REDUCE,
		ST_DIVN,
		ST_DIVD,
		ST_DONE
	} eng_state_t;

	typedef struct packed {
		logic start;
		logic skip;
		logic ack;
	} eng_ctrl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} eng_status_t;

endpackage

// File: src/fn_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fn_alu
// shared subtract and compare unit used by the gcd and division steps
// ----------------------------------------------------------------------------
module fn_alu
	import fn_pkg::*;
(
	input  logic [WIDTH-1:0] x,
	input  logic [WIDTH-1:0] y,
	output logic [WIDTH-1:0] diff,
	output logic             ge
);

	logic [WIDTH:0] full;

	assign full = {1'b0, x} - {1'b0, y};
	assign diff = full[WIDTH-1:0];
	// no borrow means x >= y
	assign ge   = ~full[WIDTH];

endmodule

// File: src/fn_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fn_engine
// sequencer: binary gcd of two magnitudes, then two restoring divisions by it
// ----------------------------------------------------------------------------
module fn_engine
	import fn_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  eng_ctrl_t        ctrl,
	input  logic [MAG_W-1:0] nmag,
	input  logic [MAG_W-1:0] dmag,
	output eng_status_t      status,
	output logic [MAG_W-1:0] rn,
	output logic [MAG_W-1:0] rd
);

	eng_state_t       state_q, state_d;
	logic [MAG_W-1:0] a_q, b_q, g_q, orig_n_q, orig_d_q, rn_q;
	logic [K_W-1:0]   k_q;
	logic [CNT_W-1:0] cnt_q;

	logic [WIDTH-1:0] alu_x, alu_y, alu_diff;
	logic             alu_ge;
	logic             a_zero, b_zero, last_bit;
	logic [MAG_W-1:0] a_shifted;

	fn_alu u_alu (
		.x    (alu_x),
		.y    (alu_y),
		.diff (alu_diff),
		.ge   (alu_ge)
	);

	assign a_zero   = (a_q == '0);
	assign b_zero   = (b_q == '0);
	assign last_bit = (cnt_q == CNT_W'(MAG_W - 1));
	assign a_shifted = {a_q[MAG_W-2:0], alu_ge};

	always_comb begin
		unique case (state_q)
			ST_DIVN, ST_DIVD: begin
				alu_x = {b_q, a_q[MAG_W-1]};
				alu_y = {1'b0, g_q};
			end
			default: begin
				alu_x = {1'b0, a_q};
				alu_y = {1'b0, b_q};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (ctrl.start) begin
					state_d = ctrl.skip ? ST_DONE : ST_STRIP;
				end
			end
			ST_STRIP: begin
				if (a_q[0] || b_q[0]) begin
					state_d = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (a_zero || b_zero) begin
					state_d = ST_DIVN;
				end
			end
			ST_DIVN: begin
				if (last_bit) begin
					state_d = ST_DIVD;
				end
			end
			ST_DIVD: begin
				if (last_bit) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (ctrl.ack) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (ctrl.start) begin
					a_q      <= nmag;
					b_q      <= dmag;
					orig_n_q <= nmag;
					orig_d_q <= dmag;
					k_q      <= '0;
				end
			end
			ST_STRIP: begin
				// common factors of two come out first
				if (!a_q[0] && !b_q[0]) begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					k_q <= k_q + K_W'(1);
				end
			end
			ST_REDUCE: begin
				priority if (a_zero || b_zero) begin
					g_q   <= (a_q | b_q) << k_q;
					a_q   <= orig_n_q;
					b_q   <= '0;
					cnt_q <= '0;
				end else if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (alu_ge) begin
					a_q <= alu_diff[MAG_W-1:0];
				end else begin
					// keep a >= b before subtracting
					a_q <= b_q;
					b_q <= a_q;
				end
			end
			ST_DIVN, ST_DIVD: begin
				if (last_bit && state_q == ST_DIVN) begin
					rn_q  <= a_shifted;
					a_q   <= orig_d_q;
					b_q   <= '0;
					cnt_q <= '0;
				end else begin
					b_q   <= alu_ge ? alu_diff[MAG_W-1:0] : alu_x[MAG_W-1:0];
					a_q   <= a_shifted;
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign status.idle = (state_q == ST_IDLE);
	assign status.done = (state_q == ST_DONE);
	assign rn          = rn_q;
	assign rd          = a_q;

endmodule

// File: src/fraction_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_normalizer
// reduces a signed fraction to lowest terms with a positive denominator
// ----------------------------------------------------------------------------
// One fraction is worked at a time. A nonzero fraction first strips its k
// common factors of two, then runs L steps of the binary gcd loop (one
// shift, subtract or swap per cycle on the shared subtractor), then two
// restoring divisions on the same subtractor. s_tready returns as the
// result enters the output register. A zero numerator or denominator
// skips the arithmetic and goes straight to the done state. A result
// that cannot leave holds the sequencer in its done state until the
// output register frees up.
// s_tready is high whenever the sequencer is idle, so the next transaction
// is taken while a finished result still waits in the output register.
// A zero denominator sets div_by_zero and returns 0/1; the most negative
// input value is treated as having the largest positive magnitude.
module fraction_normalizer
	import fn_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // num_in, den_in
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // num_out, den_out, zero pad
	output logic                   m_tuser   // div_by_zero
);

	logic signed [WIDTH-1:0] num_in, den_in;
	logic [MAG_W-1:0]        nmag, dmag, rn, rd;
	logic                    nneg, dneg, accept, load;
	eng_ctrl_t               ctrl;
	eng_status_t             status;

	logic                    neg_q, dz_q, zero_q, m_tvalid_q, m_tuser_q;
	logic [OUT_TDATA_W-1:0]  m_tdata_q;
	logic [WIDTH-1:0]        num_res;
	logic [MAG_W-1:0]        den_res;

	function automatic logic [MAG_W-1:0] magnitude(input logic [WIDTH-1:0] v);
		logic [WIDTH-1:0] m;
		m = ~v + WIDTH'(1);
		if (!v[WIDTH-1]) begin
			return v[MAG_W-1:0];
		end else if (m[WIDTH-1]) begin
			// most negative value saturates
			return '1;
		end else begin
			return m[MAG_W-1:0];
		end
	endfunction

	assign num_in = s_tdata[WIDTH-1:0];
	assign den_in = s_tdata[2*WIDTH-1:WIDTH];
	assign nneg   = num_in[WIDTH-1];
	assign dneg   = den_in[WIDTH-1];
	assign nmag   = magnitude(num_in);
	assign dmag   = magnitude(den_in);

	assign s_tready = status.idle;
	assign accept   = s_tvalid && status.idle;
	assign load     = status.done && (!m_tvalid_q || m_tready);

	assign ctrl.start = accept;
	assign ctrl.skip  = (nmag == '0) || (dmag == '0);
	assign ctrl.ack   = load;

	fn_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.nmag   (nmag),
		.dmag   (dmag),
		.status (status),
		.rn     (rn),
		.rd     (rd)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q  <= nneg ^ dneg;
			dz_q   <= (dmag == '0);
			zero_q <= (nmag == '0) || (dmag == '0);
		end
	end

	always_comb begin
		if (zero_q) begin
			num_res = '0;
			den_res = MAG_W'(1);
		end else begin
			num_res = neg_q ? (~{1'b0, rn} + WIDTH'(1)) : {1'b0, rn};
			den_res = rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= OUT_TDATA_W'({den_res, num_res});
			m_tuser_q <= dz_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// File: sim/fraction_normalizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_normalizer_tb
// streams signed fractions through the normalizer and checks every reduced
// result against a gcd-based prediction held in a scoreboard class, with
// random idling on both stream sides
// ----------------------------------------------------------------------------
module fraction_normalizer_tb;
	import fn_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 3_000_000;
	localparam int          RANDOM_ITEMS = 1930;
	localparam logic [WIDTH-1:0] MAX_POS  = {1'b0, {MAG_W{1'b1}}};
	localparam logic [WIDTH-1:0] MOST_NEG = {1'b1, {MAG_W{1'b0}}};

	typedef struct packed {
		logic [WIDTH-1:0] num;
		logic [MAG_W-1:0] den;
		logic             dz;
	} fraction_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;   // num_in, den_in
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;         // num_out, den_out, zero pad
	logic                   m_tuser;         // div_by_zero
	bit                     no_idle = 1'b0;
	int unsigned            cycle_count = 0;

	fraction_normalizer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	// most negative value saturates to the largest positive magnitude
	function automatic logic [MAG_W-1:0] magnitude_of(logic [WIDTH-1:0] v);
		logic [WIDTH-1:0] m;
		m = v[WIDTH-1] ? -v : v;
		if (m[WIDTH-1])
			m = MAX_POS;
		return m[MAG_W-1:0];
	endfunction

	function automatic fraction_t reduce_fraction(logic [WIDTH-1:0] n, logic [WIDTH-1:0] d);
		logic [MAG_W-1:0] nm, dm, a, b, r;
		fraction_t        f;
		nm = magnitude_of(n);
		dm = magnitude_of(d);
		f.num = '0;
		f.den = MAG_W'(1);
		f.dz  = 1'b0;
		if (dm == 0) begin
			f.dz = 1'b1;
		end else if (nm != 0) begin
			a = nm;
			b = dm;
			while (b != 0) begin
				r = a % b;
				a = b;
				b = r;
			end
			nm = nm / a;
			dm = dm / a;
			f.num = (n[WIDTH-1] ^ d[WIDTH-1]) ? -{1'b0, nm} : {1'b0, nm};
			f.den = dm;
		end
		return f;
	endfunction

	function automatic logic [WIDTH-1:0] with_sign(logic [WIDTH-1:0] m, bit neg);
		return neg ? -m : m;
	endfunction

	function automatic logic [WIDTH-1:0] pick_edge();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return 1;
			2:       return '1;
			3:       return MAX_POS;
			4:       return -MAX_POS;
			default: return MOST_NEG;
		endcase
	endfunction

	class fraction_scoreboard;
		fraction_t reduced_q[$];
		int        failures;
		int        reported;

		function new();
			failures = 0;
			reported = 0;
		endfunction

		function void note_fraction(logic [WIDTH-1:0] n, logic [WIDTH-1:0] d);
			reduced_q.push_back(reduce_fraction(n, d));
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic tuser);
			fraction_t want, got;
			got.num = tdata[WIDTH-1:0];
			got.den = tdata[WIDTH+MAG_W-1:WIDTH];
			got.dz  = tuser;
			if (reduced_q.size() == 0) begin
				failures++;
				if (reported < 10) begin
					reported++;
					$display("unexpected result num=%0d den=%0d div_by_zero=%0b",
						$signed(got.num), got.den, got.dz);
				end
				return;
			end
			want = reduced_q.pop_front();
			if (got !== want) begin
				failures++;
				if (reported < 10) begin
					reported++;
					$display("mismatch: expected %0d/%0d dz=%0b, got %0d/%0d dz=%0b",
						$signed(want.num), want.den, want.dz,
						$signed(got.num), got.den, got.dz);
				end
			end
		endfunction

		function int pending();
			return reduced_q.size();
		endfunction
	endclass

	fraction_scoreboard sb = new();

	task automatic send_fraction(logic [WIDTH-1:0] n, logic [WIDTH-1:0] d);
		int gap;
		@(negedge clk);
		if (!no_idle && $urandom_range(0, 99) < 4) begin
			// long gap so the next transaction lands in a different engine phase
			gap = $urandom_range(1, 180);
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		while (!no_idle && $urandom_range(0, 99) < 25) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {d, n};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_fraction(n, d);
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	always @(negedge clk)
		m_tready = no_idle ? 1'b1 : ($urandom_range(0, 99) >= 25);

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("fraction_normalizer test failed");
		$finish;
	end

	initial begin
		logic [WIDTH-1:0] n_val, d_val, g;
		int               i;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// zero denominator, zero numerator, extremes and signs
		send_fraction(0, 0);
		send_fraction(5, 0);
		send_fraction(MOST_NEG, 0);
		send_fraction(0, 7);
		send_fraction(0, -7);
		send_fraction(0, MOST_NEG);
		send_fraction(1, 1);
		send_fraction(MAX_POS, MAX_POS);
		send_fraction(-MAX_POS, MAX_POS);
		send_fraction(MAX_POS, -1);
		send_fraction(-MAX_POS, -MAX_POS);
		send_fraction(MOST_NEG, 1);
		send_fraction(1, MOST_NEG);
		send_fraction(MOST_NEG, MOST_NEG);
		send_fraction(MOST_NEG, MAX_POS);
		send_fraction(6, -4);
		send_fraction(-6, 4);
		send_fraction(-6, -4);
		send_fraction(12, 18);
		send_fraction(32'h4000_0000, 32'h0010_0000);
		send_fraction(MAX_POS, MAX_POS - 1);
		send_fraction(-1, MAX_POS);

		@(negedge clk);
		s_tvalid = 1'b0;
		wait_drained();

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			no_idle = (i >= 900 && i < 1250);
			if (i == 1400) begin
				@(negedge clk);
				s_tvalid = 1'b0;
				wait_drained();
			end
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					n_val = $urandom;
					d_val = $urandom;
				end
				3, 4, 5: begin
					// shared factor so the gcd is large
					g     = $urandom_range(1, 65535);
					n_val = with_sign(g * $urandom_range(0, 32767), 1'($urandom_range(0, 1)));
					d_val = with_sign(g * $urandom_range(1, 32767), 1'($urandom_range(0, 1)));
				end
				6: begin
					n_val = with_sign($urandom_range(1, 1 << 20) << $urandom_range(0, 10),
						1'($urandom_range(0, 1)));
					d_val = with_sign(32'd1 << $urandom_range(0, 30),
						1'($urandom_range(0, 1)));
				end
				7: begin
					n_val = pick_edge();
					d_val = $urandom_range(0, 1) ? pick_edge() : $urandom;
				end
				default: begin
					n_val = with_sign($urandom_range(0, 100), 1'($urandom_range(0, 1)));
					d_val = with_sign($urandom_range(0, 100), 1'($urandom_range(0, 1)));
				end
			endcase
			send_fraction(n_val, d_val);
		end
		no_idle = 1'b0;

		@(negedge clk);
		s_tvalid = 1'b0;
		wait_drained();
		repeat (200) @(posedge clk);

		if (sb.failures == 0 && sb.pending() == 0)
			$display("fraction_normalizer test passed");
		else
			$display("fraction_normalizer test failed");
		$finish;
	end

endmodule
